// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked in the same cycle, masked while in reset
`define GMA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// property checked in the cycle after, masked while in reset
`define GMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// property that follows a reset cycle
`define GMA_ASSERT_RESET(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/gma_pkg.sv -----
`default_nettype none

package gma_pkg;

  localparam int SampleWidth = 16;
  localparam int NumChan     = 5;
  localparam int NumGroup    = 3;
  localparam int ChanW       = $clog2(NumChan);
  localparam int GroupW      = $clog2(NumGroup);
  localparam int WinW        = 7;
  localparam int CfgIdxW     = 2;
  localparam int QuoStepW    = $clog2(SampleWidth);

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgVelocityWindow = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAccelWindow    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgYawRateWindow  = 2'd2;

  // group codes
  localparam logic [GroupW-1:0] GrpVelocity = 2'd0;
  localparam logic [GroupW-1:0] GrpAccel    = 2'd1;
  localparam logic [GroupW-1:0] GrpYawRate  = 2'd2;

  // channel codes
  localparam logic [ChanW-1:0] ChVelLong = 3'd0;
  localparam logic [ChanW-1:0] ChVelLat  = 3'd1;
  localparam logic [ChanW-1:0] ChAccLong = 3'd2;
  localparam logic [ChanW-1:0] ChAccLat  = 3'd3;
  localparam logic [ChanW-1:0] ChYawRate = 3'd4;

  typedef struct packed {
    logic signed [SampleWidth-1:0] vel_long_in;
    logic signed [SampleWidth-1:0] vel_lat_in;
    logic signed [SampleWidth-1:0] acc_long_in;
    logic signed [SampleWidth-1:0] acc_lat_in;
    logic signed [SampleWidth-1:0] yaw_rate_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] vel_long_avg;
    logic signed [SampleWidth-1:0] vel_lat_avg;
    logic signed [SampleWidth-1:0] acc_long_avg;
    logic signed [SampleWidth-1:0] acc_lat_avg;
    logic signed [SampleWidth-1:0] yaw_rate_avg;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StChStart,
    StChSum,
    StChDiv,
    StChQuo,
    StOutWait
  } gma_state_t;

  typedef struct packed {
    logic             load_in;
    logic             pass_store;
    logic             rd_issue;
    logic             acc_sum;
    logic             div_step;
    logic             div_done;
    logic             finish;
    logic [ChanW-1:0] chan;
  } gma_cmd_t;

  typedef struct packed {
    logic pass;
    logic out_free;
  } gma_status_t;

  function automatic logic [GroupW-1:0] chan_group(input logic [ChanW-1:0] c);
    logic [GroupW-1:0] g;
    case (c)
      ChVelLong, ChVelLat: g = GrpVelocity;
      ChAccLong, ChAccLat: g = GrpAccel;
      default:             g = GrpYawRate;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- src/grouped_moving_average.sv -----
`default_nettype none

// boxcar moving average over five signed q8.8 motion channels (two velocities,
// two accelerations, one yaw rate) in three groups, each with its own window
// register; a window of 0 or 1 passes samples straight through, a larger one
// (clipped to MAX_WINDOW) averages the latest samples over the current fill
// count, truncated toward zero, so the average ramps up after reset or after
// any write to that group's window register, which clears the group. one item
// is handled at a time: a pass-through channel is stored directly, an averaged
// channel steps through a history read, a sum update, 16 steps of the shared
// bit-serial divider and a result; an item is first accepted and last handed
// to the output register. the next item is taken while a finished result
// still waits at the output. the history sits in one single-port-write ram of
// 5 * 2^ceil(log2(MAX_WINDOW)) samples and needs no clearing pass

module grouped_moving_average #(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration writes
  input  wire logic                        cfg_we,
  input  wire logic [gma_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [gma_pkg::WinW-1:0]    cfg_data,
  // input items
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire gma_pkg::in_item_t           in_data,
  // result items
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output gma_pkg::out_item_t               out_data
);

  import gma_pkg::*;

  gma_cmd_t    cmd;
  gma_status_t status;

  // sequencer: channel walk and divider step count
  gma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // windows, sums, history ram, divider, output register
  gma_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

// ----- src/gma_ram.sv -----
`default_nettype none

module gma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 320
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/gma_ctrl.sv -----
`default_nettype none

module gma_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire gma_pkg::gma_status_t status,
  output gma_pkg::gma_cmd_t         cmd
);

  import gma_pkg::*;

  localparam logic [ChanW-1:0]    LastChan = ChanW'(NumChan - 1);
  localparam logic [QuoStepW-1:0] LastStep = QuoStepW'(SampleWidth - 1);

  gma_state_t          state, state_next;
  logic [ChanW-1:0]    chan, chan_next;
  logic [QuoStepW-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      chan  <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      chan  <= chan_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    chan_next  = chan;
    step_next  = step;
    cmd        = '0;
    cmd.chan   = chan;
    in_stall   = 1'b1;
    case (state)
      StIdle: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          chan_next   = '0;
          state_next  = StChStart;
        end
      end
      StChStart: begin
        if (status.pass) begin
          cmd.pass_store = 1'b1;
          if (chan == LastChan) begin
            state_next = StOutWait;
          end else begin
            chan_next = chan + 1'b1;
          end
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = StChSum;
        end
      end
      StChSum: begin
        cmd.acc_sum = 1'b1;
        step_next   = '0;
        state_next  = StChDiv;
      end
      StChDiv: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == LastStep) begin
          state_next = StChQuo;
        end
      end
      StChQuo: begin
        cmd.div_done = 1'b1;
        if (chan == LastChan) begin
          state_next = StOutWait;
        end else begin
          chan_next  = chan + 1'b1;
          state_next = StChStart;
        end
      end
      StOutWait: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = StIdle;
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/gma_datapath.sv -----
`default_nettype none

module gma_datapath #(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [gma_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [gma_pkg::WinW-1:0]     cfg_data,
  input  wire gma_pkg::in_item_t            in_data,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output gma_pkg::out_item_t                out_data,
  input  wire gma_pkg::gma_cmd_t            cmd,
  output gma_pkg::gma_status_t              status
);

  import gma_pkg::*;

  localparam int CntW     = $clog2(MAX_WINDOW + 1);
  localparam int PtrW     = $clog2(MAX_WINDOW);
  localparam int SumW     = SampleWidth + CntW;
  localparam int DivW     = CntW + SampleWidth - 1;
  localparam int RamDepth = NumChan * (2 ** PtrW);
  localparam int AddrW    = $clog2(RamDepth);

  logic [WinW-1:0]               win  [NumGroup];
  logic [CntW-1:0]               fill [NumGroup];
  logic [PtrW-1:0]               ptr  [NumGroup];
  logic signed [SumW-1:0]        sums [NumChan];
  logic signed [SampleWidth-1:0] xin  [NumChan];
  logic signed [SampleWidth-1:0] res  [NumChan];

  logic [SumW-1:0]        rem;
  logic [DivW-1:0]        dsh;
  logic [SampleWidth-1:0] quo;
  logic                   neg;

  logic [CntW-1:0]               eff  [NumGroup];
  logic                          full [NumGroup];
  logic [GroupW-1:0]             grp;
  logic signed [SampleWidth-1:0] x_cur;
  logic [SampleWidth-1:0]        rdata;
  logic signed [SumW-1:0]        x_ext, old_ext, sum_new;
  logic [SumW-1:0]               mag;
  logic [CntW-1:0]               n_cur;
  logic [AddrW-1:0]              addr;
  logic [GroupW-1:0]             cfg_grp;

  // window clipped to MAX_WINDOW
  always_comb begin
    for (int g = 0; g < NumGroup; g++) begin
      if (int'(win[g]) > MAX_WINDOW) begin
        eff[g] = CntW'(MAX_WINDOW);
      end else begin
        eff[g] = CntW'(win[g]);
      end
      full[g] = fill[g] >= eff[g];
    end
  end

  always_comb begin
    grp     = chan_group(cmd.chan);
    x_cur   = xin[cmd.chan];
    x_ext   = {{(SumW - SampleWidth){x_cur[SampleWidth-1]}}, x_cur};
    old_ext = full[grp] ? {{(SumW - SampleWidth){rdata[SampleWidth-1]}}, rdata} : '0;
    sum_new = sums[cmd.chan] - old_ext + x_ext;
    mag     = sum_new[SumW-1] ? SumW'(-sum_new) : SumW'(sum_new);
    n_cur   = full[grp] ? eff[grp] : fill[grp] + 1'b1;
    addr    = AddrW'({cmd.chan, ptr[grp]});
    cfg_grp = cfg_index[GroupW-1:0];

    status.pass     = eff[grp] <= CntW'(1);
    status.out_free = !out_valid || !out_stall;
  end

  gma_ram #(
    .WIDTH (SampleWidth),
    .DEPTH (RamDepth)
  ) u_history (
    .clk   (clk),
    .we    (cmd.acc_sum),
    .waddr (addr),
    .wdata (x_cur),
    .re    (cmd.rd_issue),
    .raddr (addr),
    .rdata (rdata)
  );

  // window registers, sums, fill counts, pointers, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NumGroup; g++) begin
        win[g]  <= WinW'(1);
        fill[g] <= '0;
        ptr[g]  <= '0;
      end
      for (int c = 0; c < NumChan; c++) begin
        sums[c] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (cfg_we && cfg_index <= CfgYawRateWindow) begin
        win[cfg_grp]  <= cfg_data;
        fill[cfg_grp] <= '0;
        ptr[cfg_grp]  <= '0;
        for (int c = 0; c < NumChan; c++) begin
          if (chan_group(ChanW'(c)) == cfg_grp) begin
            sums[c] <= '0;
          end
        end
      end
      if (cmd.acc_sum) begin
        sums[cmd.chan] <= sum_new;
      end
      if (cmd.finish) begin
        for (int g = 0; g < NumGroup; g++) begin
          if (eff[g] > CntW'(1)) begin
            if (!full[g]) begin
              fill[g] <= fill[g] + 1'b1;
            end
            if (CntW'(ptr[g]) + CntW'(1) == eff[g]) begin
              ptr[g] <= '0;
            end else begin
              ptr[g] <= ptr[g] + 1'b1;
            end
          end
        end
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: samples, divider, results
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      xin[ChVelLong] <= in_data.vel_long_in;
      xin[ChVelLat]  <= in_data.vel_lat_in;
      xin[ChAccLong] <= in_data.acc_long_in;
      xin[ChAccLat]  <= in_data.acc_lat_in;
      xin[ChYawRate] <= in_data.yaw_rate_in;
    end
    if (cmd.pass_store) begin
      res[cmd.chan] <= x_cur;
    end
    if (cmd.acc_sum) begin
      rem <= mag;
      neg <= sum_new[SumW-1];
      dsh <= DivW'(n_cur) << (SampleWidth - 1);
      quo <= '0;
    end
    if (cmd.div_step) begin
      if (rem >= SumW'(dsh)) begin
        rem <= rem - SumW'(dsh);
        quo <= {quo[SampleWidth-2:0], 1'b1};
      end else begin
        quo <= {quo[SampleWidth-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
    if (cmd.div_done) begin
      res[cmd.chan] <= neg ? (~quo + 1'b1) : quo;
    end
    if (cmd.finish) begin
      out_data.vel_long_avg <= res[ChVelLong];
      out_data.vel_lat_avg  <= res[ChVelLat];
      out_data.acc_long_avg <= res[ChAccLong];
      out_data.acc_lat_avg  <= res[ChAccLat];
      out_data.yaw_rate_avg <= res[ChYawRate];
    end
  end

endmodule

`default_nettype wire

// ----- src/gma_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module gma_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire gma_pkg::out_item_t out_data
);

  logic in_take;

  assign in_take = in_valid && !in_stall;

  `GMA_ASSERT_RESET(a_reset_empty, clk, rst, !out_valid, "output valid after reset")
  `GMA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `GMA_ASSERT_NEXT(a_busy_after_take, clk, rst, in_take, in_stall, "input not stalled while busy")
  `GMA_ASSERT_NEXT(a_no_instant_result, clk, rst, in_take, !$rose(out_valid), "result too early")
  `GMA_ASSERT_SAME(a_ready_on_result, clk, rst, $rose(out_valid), !in_stall, "not ready after result")

endmodule

bind grouped_moving_average gma_checker u_checker (.*);

`default_nettype wire
